/* hdl/pcg_pkg.sv */
`default_nettype none

package pcg_pkg;

   localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
   // stream increment, (1442695040888963407 << 1) | 1
   localparam logic [63:0] LCG_INC = 64'd2885390081777926815;

   typedef enum logic [1:0] {
      OP_RESTART  = 2'd0,
      OP_NEXT32   = 2'd1,
      OP_FRACTION = 2'd2,
      OP_BOUNDED  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      opcode;
      logic [63:0] span;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic        span_error;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/pcg_lcg_mul.sv */
`default_nettype none

module pcg_lcg_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] operand,
   output logic             done,
   output logic [63:0]      result
);

   logic        busy_ff;
   logic [1:0]  phase_ff;
   logic [63:0] a_ff;
   logic [63:0] prod_ff;
   logic [63:0] acc_ff;
   logic        done_ff;
   logic [31:0] op_a;
   logic [31:0] op_b;

   // one 32x32 multiplier, three partial products kept mod 2^64
   always_comb begin
      unique case (phase_ff)
         2'd0: begin
            op_a = a_ff[31:0];
            op_b = pcg_pkg::LCG_MULT[31:0];
         end
         2'd1: begin
            op_a = a_ff[63:32];
            op_b = pcg_pkg::LCG_MULT[31:0];
         end
         default: begin
            op_a = a_ff[31:0];
            op_b = pcg_pkg::LCG_MULT[63:32];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 2'd0;
            a_ff     <= operand;
         end else if (busy_ff) begin
            prod_ff  <= {32'b0, op_a} * {32'b0, op_b};
            phase_ff <= phase_ff + 2'd1;
            unique case (phase_ff)
               2'd0: ;
               2'd1: acc_ff <= prod_ff + pcg_pkg::LCG_INC;
               2'd2: acc_ff <= acc_ff + {prod_ff[31:0], 32'b0};
               default: begin
                  acc_ff  <= acc_ff + {prod_ff[31:0], 32'b0};
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            endcase
         end
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

/* hdl/pcg_mod_unit.sv */
`default_nettype none

module pcg_mod_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      remainder
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] dvd_ff;
   logic [63:0] dsr_ff;
   logic [63:0] rem_ff;
   logic [64:0] trial;
   logic [65:0] diff;
   logic [63:0] rem_in;

   // restoring remainder, one dividend bit per cycle
   always_comb begin
      trial  = {rem_ff, dvd_ff[63]};
      diff   = {1'b0, trial} - {2'b0, dsr_ff};
      rem_in = diff[65] ? trial[63:0] : diff[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
            rem_ff  <= 64'd0;
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[62:0], 1'b0};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* hdl/pcg32_random_generator.sv */
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_data   (pcg_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data   (pcg_pkg::rsp_type)
// csr       in         csr_valid / csr_ready  csr_data   (seed, 64 bit)
//
// one item at a time; each lcg step runs through the shared 32x32 multiplier
// a bounded draw runs the bit-serial remainder unit twice (threshold, final mod),
// and draws one more lcg pair for each rejected word
// after reset the block seeds itself with zero, req_ready low
// a finished result waits in the output register; the next item is taken meanwhile
`default_nettype none

module pcg32_random_generator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pcg_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pcg_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [63:0]      csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_STEP,
      S_WAIT,
      S_THR,
      S_CHECK,
      S_MOD,
      S_DONE
   } fsm_type;

   fsm_type          state_ff;
   pcg_pkg::op_type  op_ff;
   logic [63:0]      lcg_ff;
   logic [63:0]      seed_ff;
   logic [63:0]      span_ff;
   logic [63:0]      word_ff;
   logic [63:0]      thr_ff;
   logic             half_ff;
   logic             boot_ff;
   pcg_pkg::rsp_type res_ff;
   logic             rsp_valid_ff;
   pcg_pkg::rsp_type rsp_data_ff;
   logic             mul_start_ff;
   logic             mod_start_ff;
   logic [63:0]      mod_dvd_ff;

   logic        mul_done;
   logic [63:0] mul_result;
   logic        mod_done;
   logic [63:0] mod_rem;
   logic [63:0] seed_add;
   logic [63:0] lcg_in;
   logic        rsp_load;

   function automatic logic [31:0] xsh_rr(input logic [63:0] old);
      logic [63:0] x;
      logic [31:0] xs;
      logic [63:0] dbl;
      x   = old ^ (old >> 18);
      xs  = x[58:27];
      dbl = {xs, xs} >> old[63:59];
      return dbl[31:0];
   endfunction

   pcg_lcg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .operand (lcg_ff),
      .done    (mul_done),
      .result  (mul_result)
   );

   pcg_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start_ff),
      .dividend  (mod_dvd_ff),
      .divisor   (span_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // seed is folded in after the first step of a restart, never during the boot pass
   always_comb begin
      seed_add = (op_ff == pcg_pkg::OP_RESTART && !half_ff && !boot_ff) ? seed_ff : 64'd0;
      lcg_in   = mul_result + seed_add;
      // output register is free, or its item leaves at this edge
      rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_STEP;
         op_ff        <= pcg_pkg::OP_RESTART;
         lcg_ff       <= 64'd0;
         seed_ff      <= 64'd0;
         half_ff      <= 1'b0;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         mod_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         mod_start_ff <= 1'b0;
         if (csr_valid) begin
            seed_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff   <= req_data.opcode;
                  span_ff <= req_data.span;
                  half_ff <= 1'b0;
                  unique case (req_data.opcode)
                     pcg_pkg::OP_RESTART: begin
                        lcg_ff   <= 64'd0;
                        state_ff <= S_STEP;
                     end
                     pcg_pkg::OP_BOUNDED: begin
                        if (req_data.span == 64'd0) begin
                           res_ff.value      <= 64'd0;
                           res_ff.span_error <= 1'b1;
                           state_ff          <= S_DONE;
                        end else begin
                           // threshold = 2^64 mod span = (0 - span) mod span
                           mod_dvd_ff   <= 64'd0 - req_data.span;
                           mod_start_ff <= 1'b1;
                           state_ff     <= S_THR;
                        end
                     end
                     default: state_ff <= S_STEP;
                  endcase
               end
            end
            S_STEP: begin
               word_ff      <= {word_ff[31:0], xsh_rr(lcg_ff)};
               mul_start_ff <= 1'b1;
               state_ff     <= S_WAIT;
            end
            S_WAIT: begin
               if (mul_done) begin
                  lcg_ff  <= lcg_in;
                  half_ff <= ~half_ff;
                  unique case (op_ff)
                     pcg_pkg::OP_RESTART: begin
                        if (!half_ff) begin
                           state_ff <= S_STEP;
                        end else begin
                           boot_ff  <= 1'b0;
                           state_ff <= S_IDLE;
                        end
                     end
                     pcg_pkg::OP_NEXT32: begin
                        res_ff.value      <= {32'b0, word_ff[31:0]};
                        res_ff.span_error <= 1'b0;
                        state_ff          <= S_DONE;
                     end
                     pcg_pkg::OP_FRACTION: begin
                        if (!half_ff) begin
                           state_ff <= S_STEP;
                        end else begin
                           res_ff.value      <= {11'b0, word_ff[63:11]};
                           res_ff.span_error <= 1'b0;
                           state_ff          <= S_DONE;
                        end
                     end
                     default: begin
                        state_ff <= half_ff ? S_CHECK : S_STEP;
                     end
                  endcase
               end
            end
            S_THR: begin
               if (mod_done) begin
                  thr_ff   <= mod_rem;
                  half_ff  <= 1'b0;
                  state_ff <= S_STEP;
               end
            end
            S_CHECK: begin
               half_ff <= 1'b0;
               if (word_ff >= thr_ff) begin
                  mod_dvd_ff   <= word_ff;
                  mod_start_ff <= 1'b1;
                  state_ff     <= S_MOD;
               end else begin
                  // rejected word, draw another pair
                  state_ff <= S_STEP;
               end
            end
            S_MOD: begin
               if (mod_done) begin
                  res_ff.value      <= mod_rem;
                  res_ff.span_error <= 1'b0;
                  state_ff          <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.span_error |-> rsp_data.value == 64'd0)
      else $error("span error result carries a nonzero value");

   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_WAIT)
      else $error("multiplier finished outside the wait state");

   a_mod_done_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_THR || state_ff == S_MOD)
      else $error("remainder unit finished outside a remainder state");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("a second item was taken right after the first");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam int IDLE_LIMIT = 20000;

   // tracks the generator state and the outputs still owed by the block
   class pcg_scoreboard;
      logic [63:0]      seed_reg;
      logic [63:0]      lcg;
      pcg_pkg::rsp_type draws_due[$];
      int               errors;
      int               checked;
      int               op_count[4];
      int               zero_spans;

      function new();
         seed_reg = '0;
         errors = 0;
         checked = 0;
         zero_spans = 0;
         foreach (op_count[i]) op_count[i] = 0;
         reseed();
      endfunction

      // xsh-rr output from the old state, then one lcg step
      function logic [31:0] lcg_word();
         logic [63:0] old;
         logic [63:0] mix;
         logic [63:0] twice;
         logic [31:0] xs;
         old = lcg;
         lcg = old * pcg_pkg::LCG_MULT + pcg_pkg::LCG_INC;
         mix = old ^ (old >> 18);
         xs = mix[58:27];
         twice = {xs, xs} >> old[63:59];
         return twice[31:0];
      endfunction

      function logic [63:0] lcg_pair();
         logic [31:0] hi;
         logic [31:0] lo;
         hi = lcg_word();
         lo = lcg_word();
         return {hi, lo};
      endfunction

      function void reseed();
         logic [31:0] discard;
         lcg = '0;
         discard = lcg_word();
         lcg = lcg + seed_reg;
         discard = lcg_word();
      endfunction

      function void note_seed(logic [63:0] v);
         seed_reg = v;
      endfunction

      function void note_request(pcg_pkg::req_type r);
         pcg_pkg::rsp_type o;
         logic [63:0]      floor_word;
         logic [63:0]      w;
         op_count[int'(r.opcode)] += 1;
         o.value = '0;
         o.span_error = 1'b0;
         case (r.opcode)
            pcg_pkg::OP_RESTART: begin
               reseed();
               return;
            end
            pcg_pkg::OP_NEXT32: o.value = {32'd0, lcg_word()};
            pcg_pkg::OP_FRACTION: o.value = lcg_pair() >> 11;
            default: begin
               if (r.span == '0) begin
                  o.span_error = 1'b1;
                  zero_spans++;
               end else begin
                  // words below 2^64 mod span are redrawn to keep it unbiased
                  floor_word = (64'd0 - r.span) % r.span;
                  w = lcg_pair();
                  while (w < floor_word) w = lcg_pair();
                  o.value = w % r.span;
               end
            end
         endcase
         draws_due.push_back(o);
      endfunction

      function void check_result(pcg_pkg::rsp_type got);
         pcg_pkg::rsp_type want;
         if (draws_due.size() == 0) begin
            $error("result with nothing outstanding: value %h span_error %b",
                   got.value, got.span_error);
            errors++;
            return;
         end
         want = draws_due.pop_front();
         checked++;
         if (got.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, got.value);
            errors++;
         end
         if (got.span_error !== want.span_error) begin
            $error("span_error: expected %b, got %b", want.span_error, got.span_error);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   pcg_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   pcg_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [63:0]      csr_data;

   pcg_scoreboard sb;
   int            burst_left;
   int            idle_cycles;
   int            ready_mode;
   int            mode_left;
   int            seed_writes;
   logic [63:0]   seed_plan[5];

   always #4 clock = ~clock;

   pcg32_random_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // receiver: stretches of always-ready, coin-flip, mostly stalled and mostly ready
   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left = $urandom_range(10, 80);
         ready_mode = $urandom_range(0, 3);
      end else begin
         mode_left = mode_left - 1;
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.note_seed(csr_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
         if ((csr_valid && csr_ready) || (rsp_valid && rsp_ready) ||
             (req_valid && req_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("pcg32_random_generator test failed");
            $finish;
         end
      end
   end

   function automatic pcg_pkg::req_type make_req(pcg_pkg::op_type op, logic [63:0] span);
      pcg_pkg::req_type r;
      r.opcode = op;
      r.span = span;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] random_span();
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2: return 64'($urandom_range(1, 100));
         3: return 64'd1 << $urandom_range(0, 63);
         // just above 2^63: about half the words get redrawn
         4: return 64'h8000_0000_0000_0000 | (rand64() >> $urandom_range(1, 64));
         5: return ~64'd0 - 64'($urandom_range(0, 1000));
         6: return rand64() >> $urandom_range(0, 63);
         default: return rand64();
      endcase
   endfunction

   function automatic pcg_pkg::req_type random_req();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) return make_req(pcg_pkg::OP_RESTART, rand64());
      if (pick < 34) return make_req(pcg_pkg::OP_NEXT32, rand64());
      if (pick < 60) return make_req(pcg_pkg::OP_FRACTION, rand64());
      return make_req(pcg_pkg::OP_BOUNDED, random_span());
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic offer(input pcg_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // wait for the block to drain, including a restart that gives no result
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.draws_due.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      drain();
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      seed_writes++;
      burst_left = 0;
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      burst_left = 0;
      idle_cycles = 0;
      ready_mode = 0;
      mode_left = 0;
      seed_writes = 0;
      seed_plan[0] = 64'd1;
      seed_plan[1] = rand64();
      seed_plan[2] = 64'h8000_0000_0000_0000;
      seed_plan[3] = rand64();
      seed_plan[4] = 64'd0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // straight out of reset, self-seeded with zero
      offer(make_req(pcg_pkg::OP_NEXT32, '0));
      offer(make_req(pcg_pkg::OP_NEXT32, ~64'd0));
      offer(make_req(pcg_pkg::OP_FRACTION, 64'hAAAA_AAAA_AAAA_AAAA));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'd0));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'd1));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'd2));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'd3));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'd7));
      offer(make_req(pcg_pkg::OP_BOUNDED, ~64'd0));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'h8000_0000_0000_0000));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'h8000_0000_0000_0001));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'h0000_0001_0000_0000));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'h5555_5555_5555_5555));
      offer(make_req(pcg_pkg::OP_RESTART, ~64'd0));
      offer(make_req(pcg_pkg::OP_NEXT32, 64'h5555_5555_5555_5555));

      write_seed(~64'd0);
      offer(make_req(pcg_pkg::OP_NEXT32, '0));
      offer(make_req(pcg_pkg::OP_RESTART, '0));
      offer(make_req(pcg_pkg::OP_NEXT32, '0));
      offer(make_req(pcg_pkg::OP_FRACTION, '0));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'd10));
      offer(make_req(pcg_pkg::OP_RESTART, '0));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'hFFFF_FFFF_0000_0001));
      offer(make_req(pcg_pkg::OP_BOUNDED, 64'd0));

      foreach (seed_plan[p]) begin
         write_seed(seed_plan[p]);
         offer(make_req(pcg_pkg::OP_RESTART, rand64()));
         repeat (360) offer(random_req());
      end

      req_valid <= 1'b0;
      while (sb.draws_due.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("covered %0d restarts, %0d words, %0d fractions, %0d bounded draws",
               sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3]);
      $display("  (%0d zero spans) over %0d seed writes; %0d results checked, %0d errors",
               sb.zero_spans, seed_writes, sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("pcg32_random_generator test passed");
      end else begin
         $display("pcg32_random_generator test failed");
      end
      $finish;
   end

endmodule
